>>> hw/rtl/max_heap_priority_queue_assert.svh
// Assertion macros for the max-heap priority queue checker.
// Expects clk and arst_n to be visible where a macro is used.
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication
`define MHPQ_ASSERT_NOW(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MHPQ_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/mhpq_pkg.sv
// Shared types, sizes and codes for the max-heap priority queue.
// No dependencies; imported by every RTL module of the block.
package mhpq_pkg;

	localparam int HEAP_DEPTH = 16;
	localparam int ADDR_W     = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
	localparam int KEY_W      = 32;
	localparam int MODE_W     = 2;
	localparam int STAT_W     = 2;
	localparam int OCC_W      = 5;

	localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_EXTRACT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PEEK    = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]       mode;
		logic signed [KEY_W-1:0] key;
	} mhpq_req_t;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic signed [KEY_W-1:0] value;
		logic [OCC_W-1:0]        occupancy;
	} mhpq_rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic              start_ins;  // latch key, hole at count, count++
		logic              rd_parent;  // port A reads parent of hole
		logic              rd_kids;    // ports A/B read children of hole
		logic              take_root;  // value <= root, key <= last, count--
		logic              peek_root;  // value <= root
		logic              up_step;    // parent drops into hole, hole moves up
		logic              dn_step;    // larger child rises into hole, hole moves down
		logic              place_key;  // key written into hole
		logic              clear_val;
		logic              load_out;
		logic [STAT_W-1:0] out_status;
	} mhpq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cnt_zero;
		logic cnt_one;
		logic cnt_full;
		logic pos_zero;
		logic up_gt;
		logic dn_move;
	} mhpq_sts_t;

endpackage

>>> hw/rtl/mhpq_ctrl.sv
// Sequencer for the max-heap priority queue: request decode, sift loops,
// result handoff. Depends on mhpq_pkg.
module mhpq_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic [mhpq_pkg::MODE_W-1:0] req_mode,
	output logic                      req_ready,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	input  mhpq_pkg::mhpq_sts_t       sts,
	output mhpq_pkg::mhpq_cmd_t       cmd
);
	import mhpq_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_UP_RD   = 3'd1;
	localparam logic [2:0] S_UP_CMP  = 3'd2;
	localparam logic [2:0] S_EX_LOAD = 3'd3;
	localparam logic [2:0] S_DN_RD   = 3'd4;
	localparam logic [2:0] S_DN_CMP  = 3'd5;
	localparam logic [2:0] S_PK_LOAD = 3'd6;
	localparam logic [2:0] S_FINISH  = 3'd7;

	logic [2:0]        state_q, state_d;
	logic [STAT_W-1:0] st_q, st_d;
	logic              rsp_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.out_status = st_q;
		state_d        = state_q;
		st_d           = st_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.clear_val = 1'b1;
					st_d          = ST_OK;
					case (req_mode)
						MODE_INSERT: begin
							if (sts.cnt_full) begin
								st_d    = ST_FULL;
								state_d = S_FINISH;
							end else begin
								cmd.start_ins = 1'b1;
								state_d       = S_UP_RD;
							end
						end
						MODE_EXTRACT: begin
							if (sts.cnt_zero) begin
								st_d    = ST_EMPTY;
								state_d = S_FINISH;
							end else begin
								state_d = S_EX_LOAD;
							end
						end
						MODE_PEEK: begin
							if (sts.cnt_zero) begin
								st_d    = ST_EMPTY;
								state_d = S_FINISH;
							end else begin
								state_d = S_PK_LOAD;
							end
						end
						default: state_d = S_FINISH;
					endcase
				end
			end
			S_UP_RD: begin
				if (sts.pos_zero) begin
					cmd.place_key = 1'b1;
					state_d       = S_FINISH;
				end else begin
					cmd.rd_parent = 1'b1;
					state_d       = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (sts.up_gt) begin
					cmd.up_step = 1'b1;
					state_d     = S_UP_RD;
				end else begin
					cmd.place_key = 1'b1;
					state_d       = S_FINISH;
				end
			end
			S_EX_LOAD: begin
				cmd.take_root = 1'b1;
				state_d       = sts.cnt_one ? S_FINISH : S_DN_RD;
			end
			S_DN_RD: begin
				cmd.rd_kids = 1'b1;
				state_d     = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (sts.dn_move) begin
					cmd.dn_step = 1'b1;
					state_d     = S_DN_RD;
				end else begin
					cmd.place_key = 1'b1;
					state_d       = S_FINISH;
				end
			end
			S_PK_LOAD: begin
				cmd.peek_root = 1'b1;
				state_d       = S_FINISH;
			end
			S_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= ST_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/mhpq_datapath.sv
// Heap store, hole/key registers, occupancy counter and result register.
// Depends on mhpq_pkg; driven by mhpq_ctrl commands.
module mhpq_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mhpq_pkg::mhpq_cmd_t                 cmd,
	input  logic signed [mhpq_pkg::KEY_W-1:0]   req_key,
	output mhpq_pkg::mhpq_sts_t                 sts,
	output mhpq_pkg::mhpq_rsp_t                 rsp
);
	import mhpq_pkg::*;

	logic signed [KEY_W-1:0] mem [HEAP_DEPTH];

	logic [CNT_W-1:0]        count_q;
	logic [ADDR_W-1:0]       pos_q;
	logic signed [KEY_W-1:0] key_q, value_q, rd_a_q, rd_b_q;
	mhpq_rsp_t               rsp_q;

	logic [ADDR_W-1:0]       pos_m1, par, ra, rb;
	logic [CNT_W-1:0]        cnt_m1;
	logic [ADDR_W+1:0]       lc, rc, cnt_ext;
	logic                    lc_ok, rc_ok, gt_l, gt_r;
	logic signed [KEY_W-1:0] bval, bdat, wd;
	logic [ADDR_W-1:0]       bidx;
	logic                    we;

	assign pos_m1  = pos_q - ADDR_W'(1);
	assign par     = pos_m1 >> 1;
	assign cnt_m1  = count_q - CNT_W'(1);
	assign lc      = {1'b0, pos_q, 1'b1};
	assign rc      = lc + (ADDR_W+2)'(1);
	assign cnt_ext = (ADDR_W+2)'(count_q);

	// read addresses; root and last entry by default
	assign ra = cmd.rd_parent ? par : (cmd.rd_kids ? lc[ADDR_W-1:0] : '0);
	assign rb = cmd.rd_kids ? rc[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];

	// sift-down choice: left first, right only if strictly above the pick
	assign lc_ok = lc < cnt_ext;
	assign rc_ok = rc < cnt_ext;
	assign gt_l  = lc_ok && (rd_a_q > key_q);
	assign bval  = gt_l ? rd_a_q : key_q;
	assign gt_r  = rc_ok && (rd_b_q > bval);
	assign bdat  = gt_r ? rd_b_q : rd_a_q;
	assign bidx  = gt_r ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];

	assign we = cmd.up_step | cmd.dn_step | cmd.place_key;
	always_comb begin
		if (cmd.up_step) begin
			wd = rd_a_q;
		end else if (cmd.dn_step) begin
			wd = bdat;
		end else begin
			wd = key_q;
		end
	end

	// single write port at the hole, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[pos_q] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		rd_a_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		rd_b_q <= mem[rb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.start_ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.take_root) begin
			count_q <= cnt_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_ins) begin
			pos_q <= count_q[ADDR_W-1:0];
			key_q <= req_key;
		end else if (cmd.take_root) begin
			pos_q <= '0;
			key_q <= rd_b_q;
		end else if (cmd.up_step) begin
			pos_q <= par;
		end else if (cmd.dn_step) begin
			pos_q <= bidx;
		end

		if (cmd.clear_val) begin
			value_q <= '0;
		end else if (cmd.take_root || cmd.peek_root) begin
			value_q <= rd_a_q;
		end

		if (cmd.load_out) begin
			rsp_q.status    <= cmd.out_status;
			rsp_q.value     <= value_q;
			rsp_q.occupancy <= OCC_W'(count_q);
		end
	end

	assign rsp = rsp_q;

	assign sts.cnt_zero = (count_q == '0);
	assign sts.cnt_one  = (count_q == CNT_W'(1));
	assign sts.cnt_full = (count_q == CNT_W'(HEAP_DEPTH));
	assign sts.pos_zero = (pos_q == '0);
	assign sts.up_gt    = (key_q > rd_a_q);
	assign sts.dn_move  = gt_l | gt_r;

endmodule

>>> hw/rtl/max_heap_priority_queue.sv
// Bounded max-heap priority queue of signed 32-bit keys, 16 entries deep. One request
// (insert, extract maximum, peek maximum) gives one response with a status, the
// maximum key for a good extract or peek (zero otherwise) and the occupancy after
// the request. Requests are handled one at a time: req_ready is high only while the
// sequencer is idle, and a finished response sits in an output register so the next
// request can be taken while it waits. The sequencer goes back to idle at the edge
// that loads the response. Each level of a sift, up for an insert and down for an
// extract, takes one registered read, then a compare and a single write at the hole.
// The store needs no clearing after reset; only entries below the count are ever used.
// Depends on mhpq_pkg, mhpq_ctrl and mhpq_datapath.
module max_heap_priority_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  mhpq_pkg::mhpq_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output mhpq_pkg::mhpq_rsp_t rsp
);
	import mhpq_pkg::*;

	mhpq_cmd_t cmd;
	mhpq_sts_t sts;

	// sequencer: decodes the request, runs the sift loop, hands off the result
	mhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_mode  (req.mode),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// store with a moving hole: the key rides in a register and lands at most once
	mhpq_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.req_key (req.key),
		.sts     (sts),
		.rsp     (rsp)
	);

endmodule

>>> hw/rtl/mhpq_checker.sv
// Port-level checks for the max-heap priority queue, bound to the top level.
// Depends on mhpq_pkg and max_heap_priority_queue_assert.svh.
`include "max_heap_priority_queue_assert.svh"

module mhpq_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input mhpq_pkg::mhpq_rsp_t rsp
);
	import mhpq_pkg::*;

	`MHPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response changed while stalled")
	`MHPQ_ASSERT_NOW(a_occ_range, rsp_valid, rsp.occupancy <= OCC_W'(HEAP_DEPTH), "occupancy above depth")
	`MHPQ_ASSERT_NOW(a_full_ok, rsp_valid && rsp.status == ST_FULL, rsp.occupancy == OCC_W'(HEAP_DEPTH) && rsp.value == '0, "full status with wrong occupancy or value")
	`MHPQ_ASSERT_NOW(a_empty_ok, rsp_valid && rsp.status == ST_EMPTY, rsp.occupancy == '0 && rsp.value == '0, "empty status with wrong occupancy or value")

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (.*);

>>> sim/tb_top.sv
// Testbench for max_heap_priority_queue: directed and random insert/extract/peek traffic.
// Checks each response against a heap predictor kept inside the testbench.
// Depends on mhpq_pkg and the max_heap_priority_queue RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mhpq_pkg::*;

	// mode 3 has no package name; the block treats it as a no-op
	localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

	localparam int ITEMS          = 1950;
	localparam int QUIET_TAIL     = 300;   // last transactions run with no idling
	localparam int PHASE_LEN      = 150;   // idling on for two phases, off for one
	localparam int LONG_HOLD      = 200;   // receiver back-pressure stretch, in cycles
	localparam int LONG_HOLD_AT   = 60;    // responses seen before that stretch starts
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 40;

	typedef struct {
		mhpq_req_t req;
		bit        wait_drain;  // hold this request until every response is back
	} req_item_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	mhpq_req_t req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	mhpq_rsp_t rsp;

	req_item_t req_backlog[$];   // requests not yet offered
	mhpq_rsp_t rsp_expected[$];  // predicted responses, oldest first

	// predictor state: heap contents and occupancy
	logic signed [KEY_W-1:0] heap_kv[HEAP_DEPTH];
	int                      heap_n = 0;

	int n_sent      = 0;  // requests accepted (updated by NBA)
	int n_recv      = 0;  // responses accepted (updated by NBA)
	int n_errors    = 0;
	int stim_total  = 0;
	int gen_n       = 0;  // occupancy as tracked while building the stimulus
	bit pause_next  = 1'b0;
	int gap_left    = 0;
	int hold_left   = 0;
	bit long_done   = 1'b0;
	int quiet_count = 0;

	max_heap_priority_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #5ns clk = ~clk;

	// Apply one request to the heap copy and return the response it should give.
	// Sift up swaps only on strictly greater; sift down tries the left child first,
	// then the right one against the current pick, so ties never move.
	task automatic heap_predict(input mhpq_req_t r, output mhpq_rsp_t e);
		int                      pos;
		int                      up;
		int                      best;
		int                      lc;
		int                      rc;
		logic signed [KEY_W-1:0] t;
		e        = '0;
		e.status = ST_OK;
		case (r.mode)
		MODE_INSERT: begin
			if (heap_n >= HEAP_DEPTH) begin
				e.status = ST_FULL;
			end else begin
				pos          = heap_n;
				heap_kv[pos] = r.key;
				heap_n++;
				while (pos > 0) begin
					up = (pos - 1) / 2;
					if (!(heap_kv[pos] > heap_kv[up]))
						break;
					t            = heap_kv[pos];
					heap_kv[pos] = heap_kv[up];
					heap_kv[up]  = t;
					pos          = up;
				end
			end
		end
		MODE_EXTRACT: begin
			if (heap_n == 0) begin
				e.status = ST_EMPTY;
			end else begin
				e.value    = heap_kv[0];
				heap_kv[0] = heap_kv[heap_n - 1];
				heap_n--;
				pos = 0;
				forever begin
					best = pos;
					lc   = 2 * pos + 1;
					rc   = 2 * pos + 2;
					if (lc < heap_n && heap_kv[lc] > heap_kv[best])
						best = lc;
					if (rc < heap_n && heap_kv[rc] > heap_kv[best])
						best = rc;
					if (best == pos)
						break;
					t             = heap_kv[pos];
					heap_kv[pos]  = heap_kv[best];
					heap_kv[best] = t;
					pos           = best;
				end
			end
		end
		MODE_PEEK: begin
			if (heap_n == 0)
				e.status = ST_EMPTY;
			else
				e.value = heap_kv[0];
		end
		default: begin
			// no-op: nothing changes
		end
		endcase
		e.occupancy = OCC_W'(heap_n);
	endtask

	// Append a request to the backlog, tracking occupancy so the random part can
	// build fill and drain runs that actually reach full and empty.
	task automatic queue_req(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k);
		req_item_t it;
		it.req.mode   = m;
		it.req.key    = k;
		it.wait_drain = pause_next;
		pause_next    = 1'b0;
		req_backlog.push_back(it);
		if (m == MODE_INSERT && gen_n < HEAP_DEPTH)
			gen_n++;
		else if (m == MODE_EXTRACT && gen_n > 0)
			gen_n--;
	endtask

	// Key mix: extremes, a narrow band around zero for ties, and full-range values.
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
		0:       return 32'h7fff_ffff;
		1:       return 32'h8000_0000;
		2, 3, 4: return KEY_W'($signed($urandom_range(0, 8)) - 4);
		default: return KEY_W'($urandom);
		endcase
	endfunction

	// Driver: offers the backlog on req, predicts each accepted transaction.
	always @(posedge clk) begin
		mhpq_rsp_t want;
		bit        took;
		bit        holding;
		int        outstanding;
		bit        idle_ok;
		req_item_t it;
		if (arst_n) begin
			took    = req_valid && req_ready;
			holding = req_valid && !req_ready;
			if (took) begin
				heap_predict(req, want);
				rsp_expected.push_back(want);
				n_sent <= n_sent + 1;
			end
			// n_sent and n_recv are pre-edge values; count this edge's transaction too
			outstanding = n_sent + (took ? 1 : 0) - n_recv;
			idle_ok = (n_sent < stim_total - QUIET_TAIL) && ((n_sent / PHASE_LEN) % 3 != 2);
			if (!holding) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (req_backlog.size() == 0) begin
					req_valid <= 1'b0;
				end else if (req_backlog[0].wait_drain && outstanding != 0) begin
					req_valid <= 1'b0;
				end else begin
					it = req_backlog.pop_front();
					req       <= it.req;
					req_valid <= 1'b1;
					if (idle_ok && $urandom_range(0, 5) == 0)
						gap_left = $urandom_range(1, 15);
				end
			end
		end
	end

	// Monitor: drives rsp_ready and checks each response against the oldest prediction.
	always @(posedge clk) begin
		mhpq_rsp_t want;
		bit        idle_ok;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				n_recv <= n_recv + 1;
				if (rsp_expected.size() == 0) begin
					$error("unexpected response: status %0d value %0d occupancy %0d",
						rsp.status, rsp.value, rsp.occupancy);
					n_errors++;
				end else begin
					want = rsp_expected.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						n_errors++;
					end
					if (rsp.value !== want.value) begin
						$error("value: expected %0d, got %0d", want.value, rsp.value);
						n_errors++;
					end
					if (rsp.occupancy !== want.occupancy) begin
						$error("occupancy: expected %0d, got %0d",
							want.occupancy, rsp.occupancy);
						n_errors++;
					end
				end
			end
			idle_ok = (n_recv < stim_total - QUIET_TAIL) && ((n_recv / PHASE_LEN) % 3 != 2);
			// one long back-pressure stretch so the block fills and drops req_ready
			if (!long_done && n_recv >= LONG_HOLD_AT) begin
				long_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (idle_ok && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(0, 14);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_count <= 0;
		end else if (quiet_count >= WATCHDOG_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end else begin
			quiet_count <= quiet_count + 1;
		end
	end

	initial begin
		int n;
		int m;
		// Directed: empty-heap reads, no-op, extreme keys, ties, fill to full.
		queue_req(MODE_PEEK, '0);
		queue_req(MODE_EXTRACT, '0);
		queue_req(MODE_NOP, 32'hffff_ffff);
		queue_req(MODE_INSERT, 32'h7fff_ffff);
		queue_req(MODE_INSERT, 32'h8000_0000);
		queue_req(MODE_INSERT, 32'hffff_ffff);
		queue_req(MODE_INSERT, 32'h0000_0000);
		queue_req(MODE_INSERT, 32'd5);
		queue_req(MODE_INSERT, 32'd5);
		queue_req(MODE_PEEK, '0);
		queue_req(MODE_EXTRACT, '0);   // equal children below the new root
		for (int i = 0; i < 11; i++)
			queue_req(MODE_INSERT, KEY_W'(i * 7 - 20));  // rising keys climb far
		queue_req(MODE_INSERT, 32'h1234_5678);           // rejected, heap full
		queue_req(MODE_NOP, 32'h5555_aaaa);
		queue_req(MODE_PEEK, '0);

		// Random: fill runs, drain runs and mixed traffic, with drain pauses.
		pause_next = 1'b1;
		while (req_backlog.size() < ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				pause_next = 1'b1;
			case ($urandom_range(0, 9))
			0, 1, 2: begin
				n = HEAP_DEPTH - gen_n + $urandom_range(0, 2);
				repeat (n)
					queue_req(MODE_INSERT, pick_key());
			end
			3, 4, 5: begin
				n = gen_n + $urandom_range(0, 2);
				repeat (n) begin
					if ($urandom_range(0, 4) == 0)
						queue_req(MODE_PEEK, KEY_W'($urandom));
					queue_req(MODE_EXTRACT, KEY_W'($urandom));
				end
			end
			default: begin
				repeat ($urandom_range(8, 30)) begin
					m = $urandom_range(0, 19);
					if (m < 9)
						queue_req(MODE_INSERT, pick_key());
					else if (m < 16)
						queue_req(MODE_EXTRACT, KEY_W'($urandom));
					else if (m < 19)
						queue_req(MODE_PEEK, KEY_W'($urandom));
					else
						queue_req(MODE_NOP, KEY_W'($urandom));
				end
			end
			endcase
		end
		stim_total = req_backlog.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (req_backlog.size() != 0 || req_valid)
			@(posedge clk);
		while (n_recv != n_sent)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (rsp_expected.size() != 0)
			$error("%0d responses never arrived", rsp_expected.size());
		if (n_errors == 0 && rsp_expected.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
